[hw/rtl/pnd_pkg.sv]
// Shared types, constants and floating-point helpers for the packed code dequantizer.
package pnd_pkg;

    localparam int NCODE = 8;

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
    localparam logic [31:0] QUIET_BIT   = 32'h00400000;

    typedef enum logic [1:0] {
        REG_CODE_BITS   = 2'd0,
        REG_SCALE_BITS  = 2'd1,
        REG_OFFSET_BITS = 2'd2,
        REG_HALF_OUTPUT = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [63:0] packed_codes;
        logic        group_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value_0;
        logic [31:0] value_1;
        logic [31:0] value_2;
        logic [31:0] value_3;
        logic [31:0] value_4;
        logic [31:0] value_5;
        logic [31:0] value_6;
        logic [31:0] value_7;
        logic        result_last;
    } out_item_t;

    // Per-stage load strobes for the lane datapath.
    typedef struct packed {
        logic mul;
        logic norm;
        logic add;
        logic renorm;
        logic rnd;
        logic hprep;
        logic outp;
    } load_t;

    // Leading zero count over 36 bits; 36 when the word is zero.
    function automatic logic [5:0] lzc36(input logic [35:0] x);
        logic [5:0] n;
        logic       found;
        n     = 6'd36;
        found = 1'b0;
        for (int i = 35; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = 6'(35 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Round a normalized magnitude (MSB at bit 35, MSB weight 2^e) to fp32 or fp16,
    // nearest even; returns exponent and fraction fields without the sign.
    function automatic logic [30:0] fp_round(input logic [35:0] m,
                                             input logic signed [9:0] e,
                                             input logic hf);
        logic signed [11:0] ex;
        logic signed [11:0] bias;
        logic signed [11:0] emin;
        logic signed [11:0] shx;
        logic signed [11:0] ef;
        logic [4:0]  frac;
        logic        normal;
        logic [5:0]  sh;
        logic [36:0] mx;
        logic [36:0] rem;
        logic [36:0] hv;
        logic [36:0] msk;
        logic [35:0] r;
        logic        rnd;
        logic [30:0] inf;
        logic [30:0] bits;
        ex   = $signed({{2{e[9]}}, e});
        frac = hf ? 5'd10 : 5'd23;
        bias = hf ? 12'sd15 : 12'sd127;
        emin = 12'sd1 - bias;
        inf  = hf ? 31'h00007C00 : 31'h7F800000;
        sh   = 6'd0;
        r    = 36'd0;
        rnd  = 1'b0;
        mx   = 37'd0;
        rem  = 37'd0;
        hv   = 37'd0;
        msk  = 37'd0;
        if (ex > bias) begin
            return inf;
        end
        normal = (ex >= emin);
        shx = 12'sd35 - $signed({7'b0, frac}) + (normal ? 12'sd0 : (emin - ex));
        if (shx <= 12'sd36) begin
            sh  = shx[5:0];
            mx  = {1'b0, m};
            r   = m >> sh;
            msk = (37'd1 << sh) - 37'd1;
            rem = mx & msk;
            hv  = 37'd1 << (sh - 6'd1);
            rnd = (rem > hv) || ((rem == hv) && r[0]);
        end
        ef   = ex + bias - 12'sd1;
        bits = normal ? ({23'b0, ef[7:0]} << frac) : 31'd0;
        bits = bits + r[30:0] + {30'b0, rnd};
        if (bits >= inf) begin
            bits = inf;
        end
        return bits;
    endfunction

endpackage

[hw/rtl/pnd_unpack.sv]
// Splits one packed group into eight codes according to the code width.
module pnd_unpack (
    input  logic [63:0]                         pk,
    input  logic [3:0]                          code_bits,
    output logic [pnd_pkg::NCODE-1:0][7:0]      codes
);

    logic [3:0] depth;

    always_comb begin
        if (code_bits < 4'd4) begin
            depth = 4'd4;
        end else if (code_bits > 4'd8) begin
            depth = 4'd8;
        end else begin
            depth = code_bits;
        end
    end

    always_comb begin
        for (int k = 0; k < pnd_pkg::NCODE; k++) begin
            case (depth)
                4'd4:    codes[k] = {4'b0, pk[k*4 +: 4]};
                4'd5:    codes[k] = {3'b0, pk[k*5 +: 5]};
                4'd6:    codes[k] = {2'b0, pk[k*6 +: 6]};
                4'd7:    codes[k] = {1'b0, pk[k*7 +: 7]};
                default: codes[k] = pk[k*8 +: 8];
            endcase
        end
    end

endmodule

[hw/rtl/pnd_lane.sv]
// One lane: fused code*scale+offset to fp32, optional fp16 conversion, seven register stages.
module pnd_lane (
    input  logic            aclk,
    input  pnd_pkg::load_t  ld,
    input  logic [7:0]      code,
    input  logic [31:0]     scale,
    input  logic [31:0]     offset,
    input  logic            half,
    output logic [31:0]     value
);

    // Operand decode (the user must keep config static while items are in flight; the block does not enforce this)
    logic              ss, ts;
    logic [7:0]        sf, tf;
    logic [22:0]       sm, tm;
    logic              s_nan, s_inf, t_nan, t_inf, t_zero;
    logic [23:0]       sig_s, bm;
    logic signed [9:0] ea, eb, tb;
    logic [5:0]        lzb;
    logic [31:0]       bn;

    assign ss     = scale[31];
    assign sf     = scale[30:23];
    assign sm     = scale[22:0];
    assign ts     = offset[31];
    assign tf     = offset[30:23];
    assign tm     = offset[22:0];
    assign s_nan  = (sf == 8'hFF) && (sm != 23'd0);
    assign s_inf  = (sf == 8'hFF) && (sm == 23'd0);
    assign t_nan  = (tf == 8'hFF) && (tm != 23'd0);
    assign t_inf  = (tf == 8'hFF) && (tm == 23'd0);
    assign t_zero = (tf == 8'd0) && (tm == 23'd0);
    assign sig_s  = {sf != 8'd0, sm};
    assign bm     = {tf != 8'd0, tm};
    assign ea     = (sf != 8'd0) ? ($signed({2'b00, sf}) - 10'sd150) : -10'sd149;
    assign eb     = (tf != 8'd0) ? ($signed({2'b00, tf}) - 10'sd150) : -10'sd149;
    assign lzb    = pnd_pkg::lzc36({bm, 12'hFFF});
    assign bn     = {bm << lzb[4:0], 8'h00};
    assign tb     = eb + 10'sd23 - $signed({4'b0, lzb});

    // Stage 1: multiply
    logic [31:0] pm_reg, pm_next;
    assign pm_next = {24'b0, code} * {8'b0, sig_s};

    always_ff @(posedge aclk) begin
        if (ld.mul) begin
            pm_reg <= pm_next;
        end
    end

    // Stage 2: normalize product, resolve special operands
    logic [5:0]        lzp;
    logic [31:0]       pn_reg, pn_next;
    logic signed [9:0] pt_reg, pt_next;
    logic              ovr2_reg, ovr2_next;
    logic [31:0]       ovb2_reg, ovb2_next;

    assign lzp     = pnd_pkg::lzc36({pm_reg, 4'hF});
    assign pn_next = pm_reg << lzp[4:0];
    assign pt_next = ea + 10'sd31 - $signed({4'b0, lzp});

    always_comb begin
        ovr2_next = 1'b1;
        ovb2_next = 32'd0;
        if (s_nan) begin
            ovb2_next = scale | pnd_pkg::QUIET_BIT;
        end else if (t_nan) begin
            ovb2_next = offset | pnd_pkg::QUIET_BIT;
        end else if (s_inf) begin
            if (pm_reg == 32'd0) begin
                ovb2_next = pnd_pkg::DEFAULT_NAN;
            end else if (t_inf && (ts != ss)) begin
                ovb2_next = pnd_pkg::DEFAULT_NAN;
            end else begin
                ovb2_next = scale;
            end
        end else if (t_inf) begin
            ovb2_next = offset;
        end else if (pm_reg == 32'd0) begin
            ovb2_next = t_zero ? {ss & ts, 31'd0} : offset;
        end else begin
            ovr2_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.norm) begin
            pn_reg   <= pn_next;
            pt_reg   <= pt_next;
            ovr2_reg <= ovr2_next;
            ovb2_reg <= ovb2_next;
        end
    end

    // Stage 3: align and add with guard bits and sticky
    logic              a_big;
    logic [31:0]       bg, sml;
    logic signed [9:0] tbg, tsm;
    logic              bsg, ssg;
    logic signed [10:0] dif;
    logic [5:0]        dc;
    logic [35:0]       sm36, sh36;
    logic              lost;
    logic [34:0]       al;
    logic [35:0]       sum_next, sum_reg;
    logic signed [9:0] tbg_reg;
    logic              sgn3_reg, ovr3_reg;
    logic [31:0]       ovb3_reg;

    always_comb begin
        a_big = t_zero || (pt_reg > tb) || ((pt_reg == tb) && (pn_reg >= bn));
        bg    = a_big ? pn_reg : bn;
        sml   = a_big ? bn : pn_reg;
        tbg   = a_big ? pt_reg : tb;
        tsm   = a_big ? tb : pt_reg;
        bsg   = a_big ? ss : ts;
        ssg   = a_big ? ts : ss;
        dif   = {tbg[9], tbg} - {tsm[9], tsm};
        dc    = (dif > 11'sd35) ? 6'd36 : dif[5:0];
        sm36  = {1'b0, sml, 3'b000};
        sh36  = sm36 >> dc;
        lost  = |(sm36 & ((36'd1 << dc) - 36'd1));
        al    = {sh36[34:1], sh36[0] | lost};
        if (bsg == ssg) begin
            sum_next = {1'b0, bg, 3'b000} + {1'b0, al};
        end else begin
            sum_next = {1'b0, bg, 3'b000} - {1'b0, al};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.add) begin
            sum_reg  <= sum_next;
            tbg_reg  <= tbg;
            sgn3_reg <= bsg;
            ovr3_reg <= ovr2_reg;
            ovb3_reg <= ovb2_reg;
        end
    end

    // Stage 4: renormalize the sum
    logic [5:0]        lzs;
    logic [35:0]       nm_reg;
    logic signed [9:0] e4_reg;
    logic              zero4_reg, sgn4_reg, ovr4_reg;
    logic [31:0]       ovb4_reg;

    assign lzs = pnd_pkg::lzc36(sum_reg);

    always_ff @(posedge aclk) begin
        if (ld.renorm) begin
            nm_reg    <= sum_reg << lzs;
            e4_reg    <= tbg_reg + 10'sd1 - $signed({4'b0, lzs});
            zero4_reg <= (sum_reg == 36'd0);
            sgn4_reg  <= sgn3_reg;
            ovr4_reg  <= ovr3_reg;
            ovb4_reg  <= ovb3_reg;
        end
    end

    // Stage 5: round to fp32
    logic [31:0] f32_reg, f32_next;

    always_comb begin
        if (ovr4_reg) begin
            f32_next = ovb4_reg;
        end else if (zero4_reg) begin
            f32_next = 32'd0;
        end else begin
            f32_next = {sgn4_reg, pnd_pkg::fp_round(nm_reg, e4_reg, 1'b0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.rnd) begin
            f32_reg <= f32_next;
        end
    end

    // Stage 6: unpack the fp32 result for half conversion
    logic              hsg;
    logic [7:0]        hf;
    logic [22:0]       hfr;
    logic [23:0]       hm24;
    logic [5:0]        lzh;
    logic              hsp_next;
    logic [15:0]       hspb_next;
    logic signed [9:0] he_next;
    logic [31:0]       f32b_reg;
    logic [35:0]       hm_reg;
    logic signed [9:0] he_reg;
    logic              hsp_reg;
    logic [15:0]       hspb_reg;

    assign hsg  = f32_reg[31];
    assign hf   = f32_reg[30:23];
    assign hfr  = f32_reg[22:0];
    assign hm24 = {hf != 8'd0, hfr};
    assign lzh  = pnd_pkg::lzc36({hm24, 12'hFFF});
    assign he_next = ((hf != 8'd0) ? ($signed({2'b00, hf}) - 10'sd150) : -10'sd149)
                     + 10'sd23 - $signed({4'b0, lzh});

    always_comb begin
        hsp_next  = 1'b1;
        hspb_next = {hsg, 15'd0};
        if (hf == 8'hFF) begin
            if (hfr != 23'd0) begin
                hspb_next = {hsg, 15'h7E00 | {5'b0, hfr[22:13]}};
            end else begin
                hspb_next = {hsg, 15'h7C00};
            end
        end else if (hm24 == 24'd0) begin
            hspb_next = {hsg, 15'd0};
        end else begin
            hsp_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.hprep) begin
            f32b_reg <= f32_reg;
            hm_reg   <= {hm24 << lzh[4:0], 12'h000};
            he_reg   <= he_next;
            hsp_reg  <= hsp_next;
            hspb_reg <= hspb_next;
        end
    end

    // Stage 7: output select
    logic [30:0] hr;
    logic [31:0] value_reg, value_next;

    assign hr = pnd_pkg::fp_round(hm_reg, he_reg, 1'b1);

    always_comb begin
        if (half) begin
            value_next = {16'd0, hsp_reg ? hspb_reg : {f32b_reg[31], hr[14:0]}};
        end else begin
            value_next = f32b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.outp) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[hw/rtl/packed_nbit_dequantize.sv]
// Throughput: one group of eight codes per cycle when m_ready does not stall the output;
// the eight lanes work in parallel.
// Eight register stages: the unpack register and seven lane stages.
// A stall reaches the input in the same cycle through the ready chain; empty stages
// still load, so bubbles collapse and nothing is lost.
// Reset (aresetn low, synchronous) clears all stage valids and loads the
// register defaults: 8-bit codes, scale 1.0, offset +0.0, fp32 results.
module packed_nbit_dequantize (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  pnd_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pnd_pkg::out_item_t  m_data
);

    localparam int NST = 8;

    // Configuration registers
    logic [3:0]  code_bits_reg;
    logic [31:0] scale_bits_reg;
    logic [31:0] offset_bits_reg;
    logic        half_output_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_bits_reg   <= 4'd8;
            scale_bits_reg  <= 32'h3F800000;
            offset_bits_reg <= 32'd0;
            half_output_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (pnd_pkg::cfg_idx_e'(cfg_index))
                pnd_pkg::REG_CODE_BITS:   code_bits_reg   <= cfg_wr_data[3:0];
                pnd_pkg::REG_SCALE_BITS:  scale_bits_reg  <= cfg_wr_data;
                pnd_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_wr_data;
                pnd_pkg::REG_HALF_OUTPUT: half_output_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Stage readiness: a stage can load when it is empty or its content moves on.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 0: unpack the codes at the input transfer
    logic [pnd_pkg::NCODE-1:0][7:0] codes;
    logic [pnd_pkg::NCODE-1:0][7:0] code_reg;
    logic [NST-1:0]                 last_reg;

    pnd_unpack u_unpack (
        .pk        (s_data.packed_codes),
        .code_bits (code_bits_reg),
        .codes     (codes)
    );

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            code_reg    <= codes;
            last_reg[0] <= s_data.group_last;
        end
        for (int i = 1; i < NST; i++) begin
            if (rdy[i]) begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    // Advance lane stages together with the valid bits
    pnd_pkg::load_t ld;

    assign ld.mul    = rdy[1];
    assign ld.norm   = rdy[2];
    assign ld.add    = rdy[3];
    assign ld.renorm = rdy[4];
    assign ld.rnd    = rdy[5];
    assign ld.hprep  = rdy[6];
    assign ld.outp   = rdy[7];

    logic [pnd_pkg::NCODE-1:0][31:0] vals;

    for (genvar k = 0; k < pnd_pkg::NCODE; k++) begin : g_lane
        pnd_lane u_lane (
            .aclk   (aclk),
            .ld     (ld),
            .code   (code_reg[k]),
            .scale  (scale_bits_reg),
            .offset (offset_bits_reg),
            .half   (half_output_reg),
            .value  (vals[k])
        );
    end

    // Result transfer
    assign s_ready = rdy[0];
    assign m_valid = v_reg[NST-1];

    assign m_data.value_0     = vals[0];
    assign m_data.value_1     = vals[1];
    assign m_data.value_2     = vals[2];
    assign m_data.value_3     = vals[3];
    assign m_data.value_4     = vals[4];
    assign m_data.value_5     = vals[5];
    assign m_data.value_6     = vals[6];
    assign m_data.value_7     = vals[7];
    assign m_data.result_last = last_reg[NST-1];

`ifndef SYNTHESIS
    // Input only backs up when a result is waiting at the output.
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // A ready sink keeps the whole pipeline moving.
    a_sink_ready_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while sink is ready");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
